### rtl/graph_cluster_cut_weight_engine_defines.svh
// ----------------------------------------------------------------------------
// Graph cluster cut-weight engine assertion macros
// Shared property wrappers, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef GRAPH_CLUSTER_CUT_WEIGHT_ENGINE_DEFINES_SVH
`define GRAPH_CLUSTER_CUT_WEIGHT_ENGINE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define GCCW_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define GCCW_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/gccw_pkg.sv
// ----------------------------------------------------------------------------
// Graph cluster cut-weight engine package
// Request codes, label encoding and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package gccw_pkg;

   // request kinds carried on req_tuser
   localparam logic [2:0] REQ_WR_WEIGHT       = 3'd0;
   localparam logic [2:0] REQ_WR_LABEL        = 3'd1;
   localparam logic [2:0] REQ_OBS_VS_CLUSTER  = 3'd2;
   localparam logic [2:0] REQ_OBS_PER_CLUSTER = 3'd3;
   localparam logic [2:0] REQ_CLUSTER_SCORE   = 3'd4;

   // fixed field widths
   localparam int TYPE_W   = 3;
   localparam int IDX_W    = 8;
   localparam int CLS_W    = 6;
   localparam int WEIGHT_W = 16;
   localparam int SCALE_W  = 16;
   localparam int SCORE_W  = 49;
   localparam int MAG_W    = 48;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 56;

   // label entry: bit 6 marks unassigned, bits 5..0 hold the cluster
   localparam int LBL_W = 7;
   localparam int LBL_UNA_BIT = 6;
   localparam logic [LBL_W-1:0] LBL_UNASSIGNED = 7'h40;

   localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

   // request word layout, lowest field last
   typedef struct packed {
      logic                pad;
      logic [WEIGHT_W-1:0] weight;
      logic                unassigned;
      logic [CLS_W-1:0]    cluster_index;
      logic [IDX_W-1:0]    other_index;
      logic [IDX_W-1:0]    obs_index;
   } req_word_type;

   // result word layout, lowest field last
   typedef struct packed {
      logic               pad;
      logic [CLS_W-1:0]   cluster_id;
      logic [SCORE_W-1:0] score;
   } rsp_word_type;

endpackage

`default_nettype wire

### rtl/graph_cluster_cut_weight_engine.sv
// Writes and unknown requests go from idle straight to the result stage for their word.
// Query 2 scans its row, one weight entry read from the weight memory per cycle.
// Query 3 clears, scans the row, drains, then reads, scales and sends a word per cluster.
// Query 4 walks the whole weight memory once.
// One request is in work at a time; the next one is taken when the last word is registered.
// After reset a wipe zeroes weights and unassigns labels.
// ----------------------------------------------------------------------------
// Graph cluster cut-weight engine
// Memory-based weight matrix and label store with row scans that sum cut
// weights, a cluster accumulator memory, and a scale/saturate/negate stage.
// ----------------------------------------------------------------------------
`default_nettype none
`include "graph_cluster_cut_weight_engine_defines.svh"

module graph_cluster_cut_weight_engine #(
   parameter int NUM_OBS      = 256,
   parameter int NUM_CLUSTERS = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_tvalid,
   output      logic                              req_tready,
   // obs_index, other_index, cluster_index, unassigned, weight, zero pad
   input  wire logic [gccw_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_type
   input  wire logic [gccw_pkg::TYPE_W-1:0]       req_tuser,
   // result channel
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   // score, cluster_id, zero pad
   output      logic [gccw_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output      logic                              rsp_tlast,
   // cut scale register
   input  wire logic                              csr_wr_en,
   input  wire logic [gccw_pkg::SCALE_W-1:0]      csr_wr_data
);

   import gccw_pkg::*;

   // derived sizes
   localparam int OBS_W   = (NUM_OBS > 1) ? $clog2(NUM_OBS) : 1;
   localparam int CL_W    = (NUM_CLUSTERS > 1) ? $clog2(NUM_CLUSTERS) : 1;
   localparam int IX_W    = (OBS_W > IDX_W) ? OBS_W : IDX_W;
   localparam int ROW_W   = OBS_W + WEIGHT_W;
   localparam int ACC_W   = 2 * OBS_W + WEIGHT_W;
   localparam int PROD_W  = ACC_W + SCALE_W;
   localparam int EXT_W   = (PROD_W > SCORE_W) ? PROD_W : SCORE_W;
   localparam int W_DEPTH = 1 << (2 * OBS_W);

   // controller states
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_WIPE  = 4'd1;
   localparam logic [3:0] ST_CLR   = 4'd2;
   localparam logic [3:0] ST_SCAN  = 4'd3;
   localparam logic [3:0] ST_DRAIN = 4'd4;
   localparam logic [3:0] ST_RDS   = 4'd5;
   localparam logic [3:0] ST_MUL   = 4'd6;
   localparam logic [3:0] ST_PUT   = 4'd7;

   localparam logic [OBS_W-1:0] OBS_LAST = OBS_W'(NUM_OBS - 1);
   localparam logic [CL_W-1:0]  CL_LAST  = CL_W'(NUM_CLUSTERS - 1);

   // memories
   logic [WEIGHT_W-1:0] weight_mem [0:W_DEPTH-1];
   logic [LBL_W-1:0]    label_mem  [0:NUM_OBS-1];
   logic [ROW_W-1:0]    csum_mem   [0:NUM_CLUSTERS-1];

   // registers
   logic [3:0]          state_ff, state_in;
   logic [TYPE_W-1:0]   type_ff, type_in;
   logic [CLS_W-1:0]    cls_ff, cls_in;
   logic                obs_ok_ff, obs_ok_in;
   logic [OBS_W-1:0]    i_ff, i_in;
   logic [OBS_W-1:0]    j_ff, j_in;
   logic [CL_W-1:0]     k_ff, k_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [CLS_W-1:0]    cid_ff, cid_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic                p1_valid_ff, p1_valid_in;
   logic                p2_valid_ff, p2_valid_in;
   logic [CL_W-1:0]     p2_idx_ff, p2_idx_in;
   logic [WEIGHT_W-1:0] p2_w_ff, p2_w_in;
   logic                fw_valid_ff, fw_valid_in;
   logic [CL_W-1:0]     fw_idx_ff, fw_idx_in;
   logic [ROW_W-1:0]    fw_data_ff, fw_data_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SCORE_W-1:0]  rsp_score_ff, rsp_score_in;
   logic [CLS_W-1:0]    rsp_cid_ff, rsp_cid_in;
   logic                rsp_last_ff, rsp_last_in;
   logic [SCALE_W-1:0]  sw_ff;

   // memory read data registers
   logic [WEIGHT_W-1:0] w_rd_ff;
   logic [LBL_W-1:0]    la_rd_ff;
   logic [LBL_W-1:0]    lb_rd_ff;
   logic [ROW_W-1:0]    csum_rd_ff;

   // memory write controls
   logic                w_we;
   logic [2*OBS_W-1:0]  w_waddr;
   logic [WEIGHT_W-1:0] w_wdata;
   logic                l_we;
   logic [OBS_W-1:0]    l_waddr;
   logic [LBL_W-1:0]    l_wdata;
   logic                c_we;
   logic [CL_W-1:0]     c_waddr;
   logic [ROW_W-1:0]    c_wdata;
   logic [CL_W-1:0]     c_raddr;

   // request decode
   req_word_type        req_word;
   logic                req_accept;
   logic [IX_W-1:0]     obs_ext;
   logic [IX_W-1:0]     oth_ext;
   logic                obs_in_range;
   logic                oth_in_range;

   // scan evaluation
   logic                w_nz;
   logic                la_asg;
   logic                lb_member;
   logic                hit_out;
   logic                hit_cls;
   logic                scan_all;
   logic                scan_end;
   logic [ROW_W-1:0]    csum_old;
   logic                is_q3;
   logic                more_cls;

   // finishing math
   logic [ACC_W-1:0]    mul_op;
   logic [EXT_W-1:0]    mag_ext;
   logic [MAG_W-1:0]    mag_sat;
   rsp_word_type        rsp_word;

   assign req_word     = req_tdata;
   assign req_tready   = (state_ff == ST_IDLE);
   assign req_accept   = req_tvalid && req_tready;
   assign obs_ext      = IX_W'(req_word.obs_index);
   assign oth_ext      = IX_W'(req_word.other_index);
   assign obs_in_range = (32'(req_word.obs_index) < NUM_OBS);
   assign oth_in_range = (32'(req_word.other_index) < NUM_OBS);

   assign is_q3    = (type_ff == REQ_OBS_PER_CLUSTER);
   assign more_cls = is_q3 && (k_ff != CL_LAST);

   // hit tests on the registered row entry and labels
   assign w_nz      = (w_rd_ff != '0);
   assign la_asg    = !la_rd_ff[LBL_UNA_BIT];
   assign lb_member = !lb_rd_ff[LBL_UNA_BIT] && (lb_rd_ff[CLS_W-1:0] == cls_ff);
   assign hit_out   = p1_valid_ff && obs_ok_ff && w_nz && la_asg
                      && (la_rd_ff[CLS_W-1:0] != cls_ff)
                      && ((type_ff != REQ_CLUSTER_SCORE) || lb_member);
   assign hit_cls   = p1_valid_ff && obs_ok_ff && w_nz && la_asg
                      && (32'(la_rd_ff[CLS_W-1:0]) < NUM_CLUSTERS);

   // walk over all rows for the wipe and query 4, one row otherwise
   assign scan_all = (state_ff == ST_WIPE) || (type_ff == REQ_CLUSTER_SCORE);
   assign scan_end = (j_ff == OBS_LAST) && (!scan_all || (i_ff == OBS_LAST));

   // accumulator read with forwarding from the previous cycle's write
   assign csum_old = (fw_valid_ff && (fw_idx_ff == p2_idx_ff)) ? fw_data_ff : csum_rd_ff;

   // scale, halve, saturate and negate
   assign mul_op  = is_q3 ? ACC_W'(csum_rd_ff) : acc_ff;
   always_comb begin
      mag_ext = EXT_W'(prod_ff);
      if (type_ff == REQ_CLUSTER_SCORE) begin
         mag_ext = mag_ext >> 1;
      end
      if (|mag_ext[EXT_W-1:MAG_W]) begin
         mag_sat = '1;
      end else begin
         mag_sat = mag_ext[MAG_W-1:0];
      end
   end

   // memory write ports
   always_comb begin
      w_we    = 1'b0;
      w_waddr = {i_ff, j_ff};
      w_wdata = '0;
      l_we    = 1'b0;
      l_waddr = j_ff;
      l_wdata = LBL_UNASSIGNED;
      c_we    = 1'b0;
      c_waddr = k_ff;
      c_wdata = '0;
      if (state_ff == ST_WIPE) begin
         w_we = 1'b1;
         l_we = (i_ff == '0);
      end else if (req_accept) begin
         w_waddr = {obs_ext[OBS_W-1:0], oth_ext[OBS_W-1:0]};
         w_wdata = req_word.weight;
         w_we    = (req_tuser == REQ_WR_WEIGHT) && obs_in_range && oth_in_range;
         l_waddr = obs_ext[OBS_W-1:0];
         l_we    = (req_tuser == REQ_WR_LABEL) && obs_in_range;
         if (!req_word.unassigned && (32'(req_word.cluster_index) < NUM_CLUSTERS)) begin
            l_wdata = {1'b0, req_word.cluster_index};
         end
      end
      if (state_ff == ST_CLR) begin
         c_we = 1'b1;
      end else if (p2_valid_ff) begin
         c_we    = 1'b1;
         c_waddr = p2_idx_ff;
         c_wdata = csum_old + ROW_W'(p2_w_ff);
      end
      c_raddr = (state_ff == ST_RDS) ? k_ff : la_rd_ff[CL_W-1:0];
   end

   // weight memory
   always_ff @(posedge clock) begin
      if (w_we) begin
         weight_mem[w_waddr] <= w_wdata;
      end
      w_rd_ff <= weight_mem[{i_ff, j_ff}];
   end

   // label memory, one write and two read ports
   always_ff @(posedge clock) begin
      if (l_we) begin
         label_mem[l_waddr] <= l_wdata;
      end
      la_rd_ff <= label_mem[j_ff];
      lb_rd_ff <= label_mem[i_ff];
   end

   // per-cluster accumulator memory
   always_ff @(posedge clock) begin
      if (c_we) begin
         csum_mem[c_waddr] <= c_wdata;
      end
      csum_rd_ff <= csum_mem[c_raddr];
   end

   // controller and datapath next values
   always_comb begin
      state_in     = state_ff;
      type_in      = type_ff;
      cls_in       = cls_ff;
      obs_ok_in    = obs_ok_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      acc_in       = acc_ff;
      cid_in       = cid_ff;
      prod_in      = prod_ff;
      p1_valid_in  = 1'b0;
      p2_valid_in  = is_q3 && hit_cls;
      p2_idx_in    = la_rd_ff[CL_W-1:0];
      p2_w_in      = w_rd_ff;
      fw_valid_in  = p2_valid_ff;
      fw_idx_in    = p2_idx_ff;
      fw_data_in   = c_wdata;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_score_in = rsp_score_ff;
      rsp_cid_in   = rsp_cid_ff;
      rsp_last_in  = rsp_last_ff;

      // row sum for queries 2 and 4
      if (!is_q3 && hit_out) begin
         acc_in = acc_ff + ACC_W'(w_rd_ff);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               type_in   = req_tuser;
               cls_in    = req_word.cluster_index;
               obs_ok_in = (req_tuser == REQ_CLUSTER_SCORE) || obs_in_range;
               i_in      = (req_tuser == REQ_CLUSTER_SCORE) ? '0 : obs_ext[OBS_W-1:0];
               j_in      = '0;
               k_in      = '0;
               acc_in    = '0;
               prod_in   = '0;
               cid_in    = '0;
               unique case (req_tuser)
                  REQ_OBS_VS_CLUSTER, REQ_CLUSTER_SCORE: begin
                     cid_in   = req_word.cluster_index;
                     state_in = ST_SCAN;
                  end
                  REQ_OBS_PER_CLUSTER: begin
                     state_in = ST_CLR;
                  end
                  default: begin
                     state_in = ST_PUT;
                  end
               endcase
            end
         end
         ST_WIPE, ST_SCAN: begin
            p1_valid_in = (state_ff == ST_SCAN);
            if (j_ff == OBS_LAST) begin
               j_in = '0;
               if (scan_all) begin
                  i_in = i_ff + 1'b1;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
            if (scan_end) begin
               i_in     = '0;
               state_in = (state_ff == ST_WIPE) ? ST_IDLE : ST_DRAIN;
            end
         end
         ST_CLR: begin
            if (k_ff == CL_LAST) begin
               k_in     = '0;
               state_in = ST_SCAN;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!p1_valid_ff && !p2_valid_ff) begin
               state_in = is_q3 ? ST_RDS : ST_MUL;
            end
         end
         ST_RDS: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = PROD_W'(mul_op) * PROD_W'(sw_ff);
            state_in = ST_PUT;
         end
         ST_PUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_score_in = SCORE_W'(0) - {1'b0, mag_sat};
               rsp_cid_in   = is_q3 ? CLS_W'(k_ff) : cid_ff;
               rsp_last_in  = !more_cls;
               if (more_cls) begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_RDS;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // register update
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WIPE;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         fw_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sw_ff        <= SCALE_RESET;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         p1_valid_ff  <= p1_valid_in;
         p2_valid_ff  <= p2_valid_in;
         fw_valid_ff  <= fw_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            sw_ff <= csr_wr_data;
         end
      end
      type_ff      <= type_in;
      cls_ff       <= cls_in;
      obs_ok_ff    <= obs_ok_in;
      acc_ff       <= acc_in;
      cid_ff       <= cid_in;
      prod_ff      <= prod_in;
      p2_idx_ff    <= p2_idx_in;
      p2_w_ff      <= p2_w_in;
      fw_idx_ff    <= fw_idx_in;
      fw_data_ff   <= fw_data_in;
      rsp_score_ff <= rsp_score_in;
      rsp_cid_ff   <= rsp_cid_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // result word
   always_comb begin
      rsp_word            = '0;
      rsp_word.score      = rsp_score_ff;
      rsp_word.cluster_id = rsp_cid_ff;
   end
   assign rsp_tdata  = rsp_word;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;

   // checks
   `GCCW_ASSERT_SAME(a_rmw_only_q3, p2_valid_ff, type_ff == REQ_OBS_PER_CLUSTER,
      "accumulator update outside a per-cluster query")
   `GCCW_ASSERT_SAME(a_drained_before_read, state_ff == ST_RDS,
      !p1_valid_ff && !p2_valid_ff, "accumulator read while scan pipeline busy")
   `GCCW_ASSERT_NEXT(a_put_waits, (state_ff == ST_PUT) && rsp_valid_ff && !rsp_tready,
      state_ff == ST_PUT, "result stage moved on while output word pending")
   `GCCW_ASSERT_SAME(a_nonlast_busy, rsp_valid_ff && !rsp_last_ff,
      (type_ff == REQ_OBS_PER_CLUSTER) && (state_ff != ST_IDLE),
      "non-final word without a per-cluster query in work")

endmodule

`default_nettype wire

### tb/sv/graph_cluster_cut_weight_engine_tb.sv
// ----------------------------------------------------------------------------
// Graph cluster cut-weight engine testbench
// Streams weight writes, label writes and cut-weight queries into the engine
// under random stalls on both channels, predicts every result word from a
// private copy of the weight matrix and labels, and compares each word in
// order as it leaves the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module graph_cluster_cut_weight_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import gccw_pkg::*;

   localparam int NUM_OBS      = 256;
   localparam int NUM_CLUSTERS = 16;
   localparam int PHASES       = 5;
   localparam int PHASE_ITEMS  = 100;
   localparam int TAIL_CYCLES  = 8;
   localparam int HOT_ROWS     = 24;

   // request codes the engine does not know
   localparam logic [2:0] REQ_UNKNOWN_FIRST = 3'd5;
   localparam logic [2:0] REQ_UNKNOWN_MID   = 3'd6;
   localparam logic [2:0] REQ_UNKNOWN_LAST  = 3'd7;

   localparam bit [63:0] MAG_MAX = (64'd1 << MAG_W) - 64'd1;

   typedef struct {
      bit [TYPE_W-1:0]   kind;
      bit [IDX_W-1:0]    obs;
      bit [IDX_W-1:0]    other;
      bit [CLS_W-1:0]    cls;
      bit                una;
      bit [WEIGHT_W-1:0] wt;
   } cut_request_type;

   typedef struct {
      bit [SCORE_W-1:0] score;
      bit [CLS_W-1:0]   cluster_id;
      bit               last;
   } cut_score_type;

   // private copy of the engine state and the expected score words
   class cut_score_book;
      bit [WEIGHT_W-1:0] weights [0:NUM_OBS*NUM_OBS-1];
      bit [LBL_W-1:0]    labels [0:NUM_OBS-1];
      bit [SCALE_W-1:0]  scale;
      cut_score_type     expected_scores [$];
      int                mismatches;

      function new();
         foreach (labels[i]) labels[i] = LBL_UNASSIGNED;
         scale = SCALE_RESET;
         mismatches = 0;
      endfunction

      // row sum toward assigned neighbours outside cluster cls
      function longint unsigned row_cut(int row, bit [CLS_W-1:0] cls);
         longint unsigned sum;
         bit [WEIGHT_W-1:0] w;
         sum = 0;
         for (int j = 0; j < NUM_OBS; j++) begin
            w = weights[row * NUM_OBS + j];
            if (w != 0 && !labels[j][LBL_UNA_BIT] && labels[j][CLS_W-1:0] != cls)
               sum += w;
         end
         return sum;
      endfunction

      // scale, optional halving, saturate, negate
      function bit [SCORE_W-1:0] scaled_score(longint unsigned sum, bit halve);
         bit [63:0] mag;
         bit [63:0] neg;
         mag = sum * scale;
         if (halve) mag = mag >> 1;
         if (mag > MAG_MAX) mag = MAG_MAX;
         neg = 64'd0 - mag;
         return neg[SCORE_W-1:0];
      endfunction

      function void push_score(bit [SCORE_W-1:0] s, bit [CLS_W-1:0] c, bit l);
         cut_score_type e;
         e.score = s;
         e.cluster_id = c;
         e.last = l;
         expected_scores.insert(expected_scores.size(), e);
      endfunction

      // update the state copy and queue the words one accepted request causes
      function void note_request(cut_request_type r);
         longint unsigned sums [NUM_CLUSTERS];
         longint unsigned total;
         bit [WEIGHT_W-1:0] w;
         case (r.kind)
            REQ_WR_WEIGHT: begin
               weights[r.obs * NUM_OBS + r.other] = r.wt;
               push_score('0, '0, 1'b1);
            end
            REQ_WR_LABEL: begin
               if (r.una || r.cls >= NUM_CLUSTERS) labels[r.obs] = LBL_UNASSIGNED;
               else labels[r.obs] = {1'b0, r.cls};
               push_score('0, '0, 1'b1);
            end
            REQ_OBS_VS_CLUSTER: begin
               push_score(scaled_score(row_cut(r.obs, r.cls), 1'b0), r.cls, 1'b1);
            end
            REQ_OBS_PER_CLUSTER: begin
               foreach (sums[k]) sums[k] = 0;
               for (int j = 0; j < NUM_OBS; j++) begin
                  w = weights[r.obs * NUM_OBS + j];
                  if (w != 0 && !labels[j][LBL_UNA_BIT] && labels[j] < NUM_CLUSTERS)
                     sums[labels[j][CLS_W-1:0]] += w;
               end
               for (int k = 0; k < NUM_CLUSTERS; k++)
                  push_score(scaled_score(sums[k], 1'b0), k[CLS_W-1:0],
                             k == NUM_CLUSTERS - 1);
            end
            REQ_CLUSTER_SCORE: begin
               total = 0;
               for (int i = 0; i < NUM_OBS; i++)
                  if (!labels[i][LBL_UNA_BIT] && labels[i][CLS_W-1:0] == r.cls)
                     total += row_cut(i, r.cls);
               push_score(scaled_score(total, 1'b1), r.cls, 1'b1);
            end
            default: begin
               push_score('0, '0, 1'b1);
            end
         endcase
      endfunction

      task report_mismatch(string what);
         mismatches++;
         if (mismatches <= 100) $display("%0t ns: %s", $realtime, what);
      endtask

      // compare one accepted result word with the oldest expectation
      task check_score(bit [SCORE_W-1:0] score, bit [CLS_W-1:0] cid, bit last);
         cut_score_type e;
         if (expected_scores.size() == 0) begin
            report_mismatch($sformatf("unexpected word score %h cluster %0d last %0d",
                                      score, cid, last));
         end else begin
            e = expected_scores.pop_front();
            if (score != e.score)
               report_mismatch($sformatf("score %h, expected %h", score, e.score));
            if (cid != e.cluster_id)
               report_mismatch($sformatf("cluster_id %0d, expected %0d", cid, e.cluster_id));
            if (last != e.last)
               report_mismatch($sformatf("tlast %0d, expected %0d", last, e.last));
         end
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [TYPE_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_wr_en = 1'b0;
   logic [SCALE_W-1:0]    csr_wr_data = '0;

   bit                    quiet = 1'b0;
   cut_score_book         book;

   graph_cluster_cut_weight_engine #(
      .NUM_OBS      (NUM_OBS),
      .NUM_CLUSTERS (NUM_CLUSTERS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side stalls in bursts, none in the quiet tail
   always begin : result_stall
      @(posedge clock);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      rsp_tready <= 1'b1;
      repeat ($urandom_range(0, 30)) @(posedge clock);
   end

   // check every accepted result word
   always @(posedge clock) begin : score_watch
      rsp_word_type word;
      if (!reset && rsp_tvalid && rsp_tready) begin
         word = rsp_tdata;
         book.check_score(word.score, word.cluster_id, rsp_tlast);
      end
   end

   // hand one request word over and note it once accepted
   task send_request(cut_request_type r);
      req_word_type word;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      word.pad = 1'b0;
      word.weight = r.wt;
      word.unassigned = r.una;
      word.cluster_index = r.cls;
      word.other_index = r.other;
      word.obs_index = r.obs;
      req_tvalid <= 1'b1;
      req_tdata <= word;
      req_tuser <= r.kind;
      do @(posedge clock); while (!req_tready);
      book.note_request(r);
   endtask

   task send_fields(bit [TYPE_W-1:0] kind, bit [IDX_W-1:0] obs, bit [IDX_W-1:0] other,
                    bit [CLS_W-1:0] cls, bit una, bit [WEIGHT_W-1:0] wt);
      cut_request_type r;
      r.kind = kind;
      r.obs = obs;
      r.other = other;
      r.cls = cls;
      r.una = una;
      r.wt = wt;
      send_request(r);
   endtask

   // stop sending until every expected word is back, then let the engine settle
   task wait_for_drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (book.expected_scores.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task write_scale(bit [SCALE_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      book.scale = value;
   endtask

   // most indexes land on a small set of rows so sums build up
   function automatic bit [IDX_W-1:0] hot_index();
      if ($urandom_range(0, 99) < 85) return IDX_W'($urandom_range(0, HOT_ROWS - 1));
      return IDX_W'($urandom_range(0, NUM_OBS - 1));
   endfunction

   function automatic cut_request_type random_request();
      cut_request_type r;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 42) r.kind = REQ_WR_WEIGHT;
      else if (pick < 64) r.kind = REQ_WR_LABEL;
      else if (pick < 80) r.kind = REQ_OBS_VS_CLUSTER;
      else if (pick < 94) r.kind = REQ_OBS_PER_CLUSTER;
      else r.kind = TYPE_W'($urandom_range(REQ_UNKNOWN_FIRST, REQ_UNKNOWN_LAST));
      r.obs = hot_index();
      r.other = hot_index();
      pick = $urandom_range(0, 99);
      if (pick < 70) r.cls = CLS_W'($urandom_range(0, 5));
      else if (pick < 85) r.cls = CLS_W'($urandom_range(0, NUM_CLUSTERS - 1));
      else r.cls = CLS_W'($urandom_range(0, 63));
      r.una = ($urandom_range(0, 9) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 15) r.wt = '0;
      else if (pick < 30) r.wt = '1;
      else r.wt = WEIGHT_W'($urandom_range(0, 65535));
      return r;
   endfunction

   initial begin : stimulus
      cut_request_type r;
      bit [SCALE_W-1:0] scale_now;
      int cluster_slot;
      book = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      write_scale(SCALE_RESET);

      // directed: empty matrix, extreme weights and indexes, label corner cases
      send_fields(REQ_OBS_VS_CLUSTER, 8'd0, 8'd0, 6'd0, 1'b0, 16'h0000);
      send_fields(REQ_WR_WEIGHT, 8'd0, 8'd1, 6'd0, 1'b0, 16'hFFFF);
      send_fields(REQ_WR_WEIGHT, 8'd0, 8'd2, 6'd0, 1'b0, 16'h0100);
      send_fields(REQ_WR_WEIGHT, 8'd0, 8'd255, 6'd0, 1'b0, 16'h8000);
      send_fields(REQ_WR_WEIGHT, 8'd255, 8'd0, 6'd0, 1'b0, 16'h0001);
      send_fields(REQ_WR_WEIGHT, 8'd1, 8'd0, 6'd0, 1'b0, 16'h1234);
      send_fields(REQ_WR_WEIGHT, 8'd255, 8'd255, 6'd63, 1'b1, 16'hFFFF);
      send_fields(REQ_WR_LABEL, 8'd0, 8'd0, 6'd0, 1'b0, 16'h0000);
      send_fields(REQ_WR_LABEL, 8'd1, 8'd0, 6'd1, 1'b0, 16'h0000);
      send_fields(REQ_WR_LABEL, 8'd2, 8'd0, 6'd15, 1'b0, 16'h0000);
      // cluster beyond range and explicit unassigned mark
      send_fields(REQ_WR_LABEL, 8'd3, 8'd0, 6'd63, 1'b0, 16'h0000);
      send_fields(REQ_WR_LABEL, 8'd4, 8'd0, 6'd2, 1'b1, 16'h0000);
      send_fields(REQ_WR_LABEL, 8'd255, 8'd0, 6'd9, 1'b0, 16'h0000);
      send_fields(REQ_OBS_VS_CLUSTER, 8'd0, 8'd0, 6'd0, 1'b0, 16'h0000);
      send_fields(REQ_OBS_VS_CLUSTER, 8'd0, 8'd0, 6'd63, 1'b0, 16'h0000);
      send_fields(REQ_OBS_PER_CLUSTER, 8'd0, 8'd0, 6'd0, 1'b0, 16'h0000);
      send_fields(REQ_OBS_PER_CLUSTER, 8'd255, 8'd0, 6'd0, 1'b0, 16'h0000);
      send_fields(REQ_CLUSTER_SCORE, 8'd0, 8'd0, 6'd0, 1'b0, 16'h0000);
      // cluster with no members
      send_fields(REQ_CLUSTER_SCORE, 8'd0, 8'd0, 6'd40, 1'b0, 16'h0000);
      send_fields(REQ_UNKNOWN_FIRST, 8'd255, 8'd255, 6'd63, 1'b1, 16'hFFFF);
      send_fields(REQ_UNKNOWN_MID, 8'd7, 8'd9, 6'd3, 1'b0, 16'h00FF);
      send_fields(REQ_UNKNOWN_LAST, 8'd0, 8'd0, 6'd0, 1'b0, 16'h0000);
      // a zero weight removes the neighbour
      send_fields(REQ_WR_WEIGHT, 8'd0, 8'd2, 6'd0, 1'b0, 16'h0000);
      send_fields(REQ_OBS_VS_CLUSTER, 8'd0, 8'd0, 6'd0, 1'b0, 16'h0000);
      wait_for_drain();

      // random phases, each under its own scale
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: scale_now = '1;
            1: scale_now = '0;
            3: scale_now = 16'd1;
            default: scale_now = SCALE_W'($urandom_range(2, 65534));
         endcase
         write_scale(scale_now);
         // one full-matrix cluster query per phase, it walks every weight
         cluster_slot = $urandom_range(10, PHASE_ITEMS - 10);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == PHASES - 1 && n == PHASE_ITEMS / 2) quiet = 1'b1;
            if (phase == 0 && n == PHASE_ITEMS / 2) wait_for_drain();
            r = random_request();
            if (n == cluster_slot) r.kind = REQ_CLUSTER_SCORE;
            send_request(r);
         end
         wait_for_drain();
      end

      if (book.mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // run limit
   initial begin : watchdog
      #50_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire
